// ----- rtl/nec_ir_pulse_distance_decoder_core_defines.svh -----
// Assertion macros used by the NEC IR decoder checker.
`ifndef NEC_IR_PULSE_DISTANCE_DECODER_CORE_DEFINES_SVH
`define NEC_IR_PULSE_DISTANCE_DECODER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NIRPD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NIRPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/nirpd_pkg.sv -----
// Types, constants and helper functions for the NEC IR pulse-distance decoder.
`default_nettype none
package nirpd_pkg;

   localparam int CAP_W     = 16;
   localparam int TICKS_W   = 17;
   localparam int US_W      = 20;
   localparam int CNT_W     = 6;
   localparam int WORD_W    = 32;
   localparam int BIT_IDX_W = 5;
   localparam int CMD_W     = 8;
   localparam int CSR_IDX_W = 4;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_REPEAT_LOW  = 4'd0,
      REG_REPEAT_HIGH = 4'd1,
      REG_LEADER_LOW  = 4'd2,
      REG_LEADER_HIGH = 4'd3,
      REG_ZERO_LOW    = 4'd4,
      REG_ZERO_HIGH   = 4'd5,
      REG_ONE_LOW     = 4'd6,
      REG_ONE_HIGH    = 4'd7
   } csr_reg_type;

   // Reset values of the timing windows, in microseconds.
   localparam logic [US_W-1:0] RST_REPEAT_LOW  = 20'd10000;
   localparam logic [US_W-1:0] RST_REPEAT_HIGH = 20'd12000;
   localparam logic [US_W-1:0] RST_LEADER_LOW  = 20'd13000;
   localparam logic [US_W-1:0] RST_LEADER_HIGH = 20'd14000;
   localparam logic [US_W-1:0] RST_ZERO_LOW    = 20'd1000;
   localparam logic [US_W-1:0] RST_ZERO_HIGH   = 20'd1500;
   localparam logic [US_W-1:0] RST_ONE_LOW     = 20'd2000;
   localparam logic [US_W-1:0] RST_ONE_HIGH    = 20'd2500;

   typedef struct packed {
      logic [US_W-1:0] repeat_low;
      logic [US_W-1:0] repeat_high;
      logic [US_W-1:0] leader_low;
      logic [US_W-1:0] leader_high;
      logic [US_W-1:0] zero_low;
      logic [US_W-1:0] zero_high;
      logic [US_W-1:0] one_low;
      logic [US_W-1:0] one_high;
   } window_cfg_type;

   // One measured interval leaving the capture stage.
   typedef struct packed {
      logic            valid;
      logic [US_W-1:0] us;
   } meas_type;

   // One decoded result heading for the output register.
   typedef struct packed {
      logic              emit;
      logic [WORD_W-1:0] word;
      logic              is_repeat;
   } result_type;

   // True when the interval lies strictly between the two bounds.
   function automatic logic in_window(input logic [US_W-1:0] us,
                                      input logic [US_W-1:0] lo,
                                      input logic [US_W-1:0] hi);
      return (us > lo) && (us < hi);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/nirpd_csr.sv -----
// Configuration registers holding the four timing windows.
`default_nettype none
module nirpd_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   input  wire logic [nirpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [nirpd_pkg::US_W-1:0]     csr_data,
   output logic                                csr_ready,
   output nirpd_pkg::window_cfg_type           cfg
);
   import nirpd_pkg::*;

   window_cfg_type cfg_ff;
   window_cfg_type cfg_in;

   // Writes are always taken; indexes past the register list are dropped.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_REPEAT_LOW:  cfg_in.repeat_low  = csr_data;
            REG_REPEAT_HIGH: cfg_in.repeat_high = csr_data;
            REG_LEADER_LOW:  cfg_in.leader_low  = csr_data;
            REG_LEADER_HIGH: cfg_in.leader_high = csr_data;
            REG_ZERO_LOW:    cfg_in.zero_low    = csr_data;
            REG_ZERO_HIGH:   cfg_in.zero_high   = csr_data;
            REG_ONE_LOW:     cfg_in.one_low     = csr_data;
            REG_ONE_HIGH:    cfg_in.one_high    = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Window registers with their reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_low  <= RST_REPEAT_LOW;
         cfg_ff.repeat_high <= RST_REPEAT_HIGH;
         cfg_ff.leader_low  <= RST_LEADER_LOW;
         cfg_ff.leader_high <= RST_LEADER_HIGH;
         cfg_ff.zero_low    <= RST_ZERO_LOW;
         cfg_ff.zero_high   <= RST_ZERO_HIGH;
         cfg_ff.one_low     <= RST_ONE_LOW;
         cfg_ff.one_high    <= RST_ONE_HIGH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/nirpd_interval.sv -----
// Capture input register and interval measurement in microseconds.
`default_nettype none
module nirpd_interval #(
   parameter int TICK_US = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic [nirpd_pkg::CAP_W-1:0]  req_capture_value,
   input  wire logic                         advance,
   output nirpd_pkg::meas_type               meas
);
   import nirpd_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   logic [CAP_W-1:0]   cap_ff;
   logic [CAP_W-1:0]   cap_in;
   logic [CAP_W-1:0]   prev_ff;
   logic [CAP_W-1:0]   prev_in;
   logic               accept;
   logic               consume;
   logic [CAP_W-1:0]   diff;
   logic [TICKS_W-1:0] ticks;

   assign accept  = req_valid && !req_stall;
   assign consume = valid_ff && advance;

   // Input register: load on accept, hold while the stage is stalled.
   always_comb begin
      valid_in = accept || (valid_ff && !advance);
      cap_in   = accept ? req_capture_value : cap_ff;
      prev_in  = consume ? cap_ff : prev_ff;
   end

   // Wrapped tick difference; a zero difference stands for a full timer period.
   always_comb begin
      diff  = cap_ff - prev_ff;
      ticks = (diff == '0) ? {1'b1, {CAP_W{1'b0}}} : {1'b0, diff};
   end

   assign meas.valid = valid_ff;
   assign meas.us    = US_W'(US_W'(ticks) * US_W'(TICK_US));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         prev_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         prev_ff  <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff <= cap_in;
   end

endmodule
`default_nettype wire

// ----- rtl/nirpd_frame.sv -----
// Interval classification and frame assembly state.
`default_nettype none
module nirpd_frame #(
   parameter int FRAME_INTERVALS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire nirpd_pkg::meas_type       meas,
   input  wire logic                      advance,
   input  wire nirpd_pkg::window_cfg_type cfg,
   output nirpd_pkg::result_type          result
);
   import nirpd_pkg::*;

   logic              leader_ff, leader_in, leader_next;
   logic              repeat_ff, repeat_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_next;
   logic [CNT_W-1:0]  pos_ff, pos_in, pos_next;
   logic [WORD_W-1:0] acc_ff, acc_in, acc_next;
   logic [WORD_W-1:0] last_ff, last_in;
   logic              is_rep_win;
   logic              is_leader_win;
   logic              is_zero;
   logic              is_one;

   // Window compares, all in parallel.
   assign is_rep_win    = in_window(meas.us, cfg.repeat_low, cfg.repeat_high);
   assign is_leader_win = in_window(meas.us, cfg.leader_low, cfg.leader_high);
   assign is_zero       = in_window(meas.us, cfg.zero_low, cfg.zero_high);
   assign is_one        = !is_zero && in_window(meas.us, cfg.one_low, cfg.one_high);

   // Next state and result for the interval in the capture stage.
   always_comb begin
      leader_in   = leader_ff;
      repeat_in   = repeat_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      acc_in      = acc_ff;
      last_in     = last_ff;
      leader_next = leader_ff;
      cnt_next    = cnt_ff;
      pos_next    = pos_ff;
      acc_next    = acc_ff;
      result      = '0;
      if (meas.valid && advance) begin
         if (is_rep_win) begin
            // Every second repeat interval re-sends the last frame.
            if (repeat_ff) begin
               repeat_in        = 1'b0;
               cnt_in           = '0;
               pos_in           = '0;
               acc_in           = '0;
               result.emit      = 1'b1;
               result.word      = last_ff;
               result.is_repeat = 1'b1;
            end else begin
               repeat_in = 1'b1;
            end
         end else begin
            if (leader_ff) begin
               if ((is_zero || is_one) && (pos_ff < CNT_W'(WORD_W))) begin
                  if (is_one) begin
                     acc_next[pos_ff[BIT_IDX_W-1:0]] = 1'b1;
                  end
                  pos_next = pos_ff + 1'b1;
               end
               cnt_next = cnt_ff + 1'b1;
            end else if (is_leader_win) begin
               leader_next = 1'b1;
            end else begin
               cnt_next = '0;
               pos_next = '0;
               acc_next = '0;
            end
            // The last interval of a frame closes it.
            if (cnt_next == CNT_W'(FRAME_INTERVALS)) begin
               result.emit      = 1'b1;
               result.word      = acc_next;
               result.is_repeat = 1'b0;
               last_in          = acc_next;
               leader_next      = 1'b0;
               cnt_next         = '0;
               pos_next         = '0;
               acc_next         = '0;
            end
            leader_in = leader_next;
            cnt_in    = cnt_next;
            pos_in    = pos_next;
            acc_in    = acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leader_ff <= 1'b0;
         repeat_ff <= 1'b0;
         cnt_ff    <= '0;
         pos_ff    <= '0;
         acc_ff    <= '0;
         last_ff   <= '0;
      end else begin
         leader_ff <= leader_in;
         repeat_ff <= repeat_in;
         cnt_ff    <= cnt_in;
         pos_ff    <= pos_in;
         acc_ff    <= acc_in;
         last_ff   <= last_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/nirpd_out.sv -----
// Result register that holds a transaction until the consumer takes it.
`default_nettype none
module nirpd_out (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire nirpd_pkg::result_type        result,
   input  wire logic                         rsp_stall,
   output logic                              out_free,
   output logic                              rsp_valid,
   output logic [nirpd_pkg::CMD_W-1:0]       rsp_command_byte,
   output logic [nirpd_pkg::WORD_W-1:0]      rsp_frame_word,
   output logic                              rsp_is_repeat
);
   import nirpd_pkg::*;

   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              rep_ff, rep_in;

   // The register can take a new result when empty or being drained.
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = out_free ? result.emit : valid_ff;
      word_in  = (out_free && result.emit) ? result.word : word_ff;
      rep_in   = (out_free && result.emit) ? result.is_repeat : rep_ff;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_frame_word   = word_ff;
   assign rsp_command_byte = word_ff[23:16];
   assign rsp_is_repeat    = rep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rep_ff  <= rep_in;
   end

endmodule
`default_nettype wire

// ----- rtl/nec_ir_pulse_distance_decoder_core.sv -----
// A capture taken into the capture register is classified by the frame logic, and any
// result it yields enters the result register once that register is free.
// Throughput: one capture per cycle; the capture register advances whenever the
// result register is empty or being drained, so rsp_stall backs up into req_stall.
// Reset (synchronous, active high) clears the frame state, the previous capture,
// both valid flags and loads the default timing windows.
`default_nettype none
module nec_ir_pulse_distance_decoder_core #(
   parameter int FRAME_INTERVALS = 32,
   parameter int TICK_US         = 10
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [nirpd_pkg::CAP_W-1:0]     req_capture_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [nirpd_pkg::CMD_W-1:0]          rsp_command_byte,
   output logic [nirpd_pkg::WORD_W-1:0]         rsp_frame_word,
   output logic                                 rsp_is_repeat,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [nirpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [nirpd_pkg::US_W-1:0]      csr_data
);
   import nirpd_pkg::*;

   window_cfg_type cfg;
   meas_type       meas;
   result_type     result;
   logic           out_free;

   // The capture stage stalls only when it holds an item that cannot move on.
   assign req_stall = meas.valid && !out_free;

   nirpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   nirpd_interval #(
      .TICK_US (TICK_US)
   ) u_interval (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_capture_value (req_capture_value),
      .advance           (out_free),
      .meas              (meas)
   );

   nirpd_frame #(
      .FRAME_INTERVALS (FRAME_INTERVALS)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .meas    (meas),
      .advance (out_free),
      .cfg     (cfg),
      .result  (result)
   );

   nirpd_out u_out (
      .clock            (clock),
      .reset            (reset),
      .result           (result),
      .rsp_stall        (rsp_stall),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_command_byte (rsp_command_byte),
      .rsp_frame_word   (rsp_frame_word),
      .rsp_is_repeat    (rsp_is_repeat)
   );

endmodule
`default_nettype wire

// ----- rtl/nirpd_checker.sv -----
// Port-level checks for the NEC IR decoder, bound to the top level.
`default_nettype none
`include "nec_ir_pulse_distance_decoder_core_defines.svh"
module nirpd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic [nirpd_pkg::CMD_W-1:0]     rsp_command_byte,
   input wire logic [nirpd_pkg::WORD_W-1:0]    rsp_frame_word,
   input wire logic                            rsp_is_repeat
);
   import nirpd_pkg::*;

   // A stalled result holds its payload.
   `NIRPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_frame_word) && $stable(rsp_is_repeat))

   // The command byte is always the third byte of the frame word.
   `NIRPD_ASSERT_SAME(a_cmd_byte, clock, reset, rsp_valid,
      rsp_command_byte == rsp_frame_word[23:16])

   // A new result needs an earlier capture that went through the capture register.
   `NIRPD_ASSERT_SAME(a_rsp_cause, clock, reset, $rose(rsp_valid),
      $past(req_valid && !req_stall, 2))

   // The input side stalls only while a result is held back.
   `NIRPD_ASSERT_SAME(a_stall_cause, clock, reset, req_stall,
      rsp_valid && rsp_stall)

endmodule

bind nec_ir_pulse_distance_decoder_core nirpd_checker u_nirpd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_command_byte (rsp_command_byte),
   .rsp_frame_word   (rsp_frame_word),
   .rsp_is_repeat    (rsp_is_repeat)
);
`default_nettype wire
